>>> rtl/dpfl_pkg.sv
`default_nettype none

package dpfl_pkg;

    localparam int PAGE_WORDS  = 8;
    localparam int FRAME_COUNT = 4;
    localparam int PAGE_COUNT  = 16;
    localparam int DATA_WIDTH  = 32;

    localparam int OFF_W     = $clog2(PAGE_WORDS);
    localparam int FRAME_W   = $clog2(FRAME_COUNT);
    localparam int PAGE_W    = $clog2(PAGE_COUNT);
    localparam int VADDR_W   = 7;
    localparam int PHYS_AW   = FRAME_W + OFF_W;
    localparam int BACK_AW   = PAGE_W + OFF_W;
    localparam int PHYS_SIZE = PAGE_WORDS * FRAME_COUNT;
    localparam int BACK_SIZE = PAGE_WORDS * PAGE_COUNT;
    localparam int CNT_W     = OFF_W + 1;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    typedef struct packed {
        logic               op;
        logic [VADDR_W-1:0] vaddr;
        data_t              wdata;
    } req_t;

    typedef struct packed {
        data_t              rdata;
        logic               fault;
        logic               evicted;
        logic [PAGE_W-1:0]  victim_page;
        logic               wrote_back;
        logic [FRAME_W-1:0] frame;
    } rsp_t;

    typedef enum logic [0:0] {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        POL_FIFO = 1'b0,
        POL_LRU  = 1'b1
    } policy_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_VICT,
        S_WB,
        S_FILL,
        S_ACC,
        S_RD,
        S_DONE
    } state_t;

    // Page table command, one cycle wide.
    typedef struct packed {
        logic [PAGE_W-1:0]  addr;
        logic [FRAME_W-1:0] frame;
        logic               alloc;
        logic               unmap;
        logic               map;
        logic               touch;
        logic               mark_dirty;
    } ptab_cmd_t;

    typedef struct packed {
        logic               valid;
        logic               dirty;
        logic [FRAME_W-1:0] frame;
        logic [FRAME_W-1:0] alloc_frame;
        logic               alloc_evict;
        logic [PAGE_W-1:0]  alloc_owner;
    } ptab_stat_t;

    typedef struct packed {
        logic               phys_we;
        logic [PHYS_AW-1:0] phys_waddr;
        logic [PHYS_AW-1:0] phys_raddr;
        logic               back_we;
        logic [BACK_AW-1:0] back_waddr;
        logic [BACK_AW-1:0] back_raddr;
    } mem_ctl_t;

endpackage

`default_nettype wire

>>> rtl/dpfl_ptab.sv
`default_nettype none

module dpfl_ptab (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dpfl_pkg::policy_t      policy,
    input  dpfl_pkg::ptab_cmd_t    cmd,
    output dpfl_pkg::ptab_stat_t   stat
);

    logic                         valid_reg [dpfl_pkg::PAGE_COUNT];
    logic                         dirty_reg [dpfl_pkg::PAGE_COUNT];
    logic [dpfl_pkg::FRAME_W-1:0] pframe_reg [dpfl_pkg::PAGE_COUNT];
    logic [dpfl_pkg::PAGE_W-1:0]  owner_reg [dpfl_pkg::FRAME_COUNT];
    logic                         used_reg [dpfl_pkg::FRAME_COUNT];
    logic [dpfl_pkg::FRAME_W-1:0] rank_reg [dpfl_pkg::FRAME_COUNT];
    logic [dpfl_pkg::FRAME_W-1:0] rank_next [dpfl_pkg::FRAME_COUNT];
    logic [dpfl_pkg::FRAME_W-1:0] fifo_reg;
    logic [dpfl_pkg::FRAME_W-1:0] fifo_next;
    logic [dpfl_pkg::FRAME_W-1:0] free_frame;
    logic                         any_free;
    logic [dpfl_pkg::FRAME_W-1:0] lru_frame;
    logic [dpfl_pkg::FRAME_W-1:0] victim;
    logic [dpfl_pkg::FRAME_COUNT-1:0] rank_seen;

    always_comb
    begin
        // Lowest free frame wins.
        any_free   = 1'b0;
        free_frame = '0;
        for (int i = dpfl_pkg::FRAME_COUNT - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                any_free   = 1'b1;
                free_frame = dpfl_pkg::FRAME_W'(i);
            end
        end

        lru_frame = '0;
        for (int i = 1; i < dpfl_pkg::FRAME_COUNT; i++)
        begin
            if (rank_reg[i] > rank_reg[lru_frame])
            begin
                lru_frame = dpfl_pkg::FRAME_W'(i);
            end
        end

        victim = (policy == dpfl_pkg::POL_LRU) ? lru_frame : fifo_reg;

        stat.valid       = valid_reg[cmd.addr];
        stat.dirty       = dirty_reg[cmd.addr];
        stat.frame       = pframe_reg[cmd.addr];
        stat.alloc_evict = !any_free;
        stat.alloc_frame = any_free ? free_frame : victim;
        stat.alloc_owner = owner_reg[victim];

        fifo_next = fifo_reg;
        if (cmd.alloc && !any_free && policy == dpfl_pkg::POL_FIFO)
        begin
            fifo_next = fifo_reg + 1'b1;
        end

        // Frames more recent than the touched one age by one.
        for (int i = 0; i < dpfl_pkg::FRAME_COUNT; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (cmd.touch && rank_reg[i] < rank_reg[cmd.frame])
            begin
                rank_next[i] = rank_reg[i] + 1'b1;
            end
        end
        if (cmd.touch)
        begin
            rank_next[cmd.frame] = '0;
        end

        for (int i = 0; i < dpfl_pkg::FRAME_COUNT; i++)
        begin
            rank_seen[i] = 1'b0;
            for (int j = 0; j < dpfl_pkg::FRAME_COUNT; j++)
            begin
                if (rank_reg[j] == dpfl_pkg::FRAME_W'(i))
                begin
                    rank_seen[i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dpfl_pkg::PAGE_COUNT; i++)
            begin
                valid_reg[i]  <= 1'b0;
                dirty_reg[i]  <= 1'b0;
                pframe_reg[i] <= '0;
            end
            for (int i = 0; i < dpfl_pkg::FRAME_COUNT; i++)
            begin
                owner_reg[i] <= '0;
                used_reg[i]  <= 1'b0;
                rank_reg[i]  <= dpfl_pkg::FRAME_W'(i);
            end
            fifo_reg <= '0;
        end
        else
        begin
            if (cmd.unmap)
            begin
                valid_reg[cmd.addr] <= 1'b0;
                dirty_reg[cmd.addr] <= 1'b0;
            end
            if (cmd.map)
            begin
                valid_reg[cmd.addr]  <= 1'b1;
                dirty_reg[cmd.addr]  <= 1'b0;
                pframe_reg[cmd.addr] <= cmd.frame;
                used_reg[cmd.frame]  <= 1'b1;
                owner_reg[cmd.frame] <= cmd.addr;
            end
            if (cmd.mark_dirty)
            begin
                dirty_reg[cmd.addr] <= 1'b1;
            end
            for (int i = 0; i < dpfl_pkg::FRAME_COUNT; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
            fifo_reg <= fifo_next;
        end
    end

    // The recency ranks must always be a permutation of the frames.
    a_rank_perm: assert property (@(posedge clk) disable iff (!rst_n)
        &rank_seen)
        else $error("lru ranks are not a permutation");

    // A resident page is owned by the frame it maps to.
    a_owner_back: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[cmd.addr] |-> owner_reg[pframe_reg[cmd.addr]] == cmd.addr)
        else $error("page table and frame owner disagree");

    // Only a resident page is ever unmapped.
    a_unmap_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.unmap |-> valid_reg[cmd.addr])
        else $error("unmap of a page that is not resident");

endmodule

`default_nettype wire

>>> rtl/dpfl_store.sv
`default_nettype none

module dpfl_store (
    input  logic               clk,
    input  logic               rst_n,
    input  dpfl_pkg::mem_ctl_t ctl,
    input  dpfl_pkg::data_t    phys_wdata,
    input  dpfl_pkg::data_t    back_wdata,
    output dpfl_pkg::data_t    phys_rdata,
    output dpfl_pkg::data_t    back_rdata
);

    dpfl_pkg::data_t phys_mem [dpfl_pkg::PHYS_SIZE];
    dpfl_pkg::data_t back_mem [dpfl_pkg::BACK_SIZE];
    logic            back_vld_reg [dpfl_pkg::BACK_SIZE];
    dpfl_pkg::data_t phys_rd_reg;
    dpfl_pkg::data_t back_rd_reg;
    logic            back_rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.phys_we)
        begin
            phys_mem[ctl.phys_waddr] <= phys_wdata;
        end
        phys_rd_reg <= phys_mem[ctl.phys_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.back_we)
        begin
            back_mem[ctl.back_waddr] <= back_wdata;
        end
        back_rd_reg <= back_mem[ctl.back_raddr];
    end

    // Backing words never written read as all ones.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dpfl_pkg::BACK_SIZE; i++)
            begin
                back_vld_reg[i] <= 1'b0;
            end
            back_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.back_we)
            begin
                back_vld_reg[ctl.back_waddr] <= 1'b1;
            end
            back_rd_vld_reg <= back_vld_reg[ctl.back_raddr];
        end
    end

    assign phys_rdata = phys_rd_reg;
    assign back_rdata = back_rd_vld_reg ? back_rd_reg : '1;

endmodule

`default_nettype wire

>>> rtl/demand_paging_fifo_lru_unit.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_req  (op, vaddr, wdata)
// out       output     out_valid / out_stall out_rsp (rdata, fault, evicted, ...)
// cfg       input      cfg_valid / cfg_ready cfg_data (policy)
//
// A hit passes through lookup, access, read and done; a fault also loads the page,
// an eviction also looks up the evicted page, and a dirty victim is also written back.
// The page copies move one word per cycle through a single port of each memory.
// Async reset clears page table, FIFO pointer, policy; ranks go to frame order.
// A new request is taken while the previous result still waits on out_stall.

`default_nettype none

module demand_paging_fifo_lru_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  dpfl_pkg::req_t in_req,
    output logic           out_valid,
    input  logic           out_stall,
    output dpfl_pkg::rsp_t out_rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_data
);

    dpfl_pkg::state_t             state_reg, state_next;
    dpfl_pkg::policy_t            policy_reg, policy_next;
    logic                         out_valid_reg, out_valid_next;
    dpfl_pkg::rsp_t               out_rsp_reg, out_rsp_next;
    dpfl_pkg::op_t                op_reg, op_next;
    logic [dpfl_pkg::PAGE_W-1:0]  page_reg, page_next;
    logic [dpfl_pkg::OFF_W-1:0]   off_reg, off_next;
    dpfl_pkg::data_t              wdata_reg, wdata_next;
    logic [dpfl_pkg::FRAME_W-1:0] frame_reg, frame_next;
    logic                         fault_reg, fault_next;
    logic                         ev_reg, ev_next;
    logic [dpfl_pkg::PAGE_W-1:0]  vp_reg, vp_next;
    logic                         wb_reg, wb_next;
    logic [dpfl_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    dpfl_pkg::data_t              rdata_reg, rdata_next;

    dpfl_pkg::ptab_cmd_t          pt_cmd;
    dpfl_pkg::ptab_stat_t         pt_stat;
    dpfl_pkg::mem_ctl_t           mem_ctl;
    dpfl_pkg::data_t              phys_wdata;
    dpfl_pkg::data_t              phys_rdata;
    dpfl_pkg::data_t              back_rdata;
    logic [dpfl_pkg::OFF_W-1:0]   rd_off;
    logic [dpfl_pkg::OFF_W-1:0]   wr_off;
    logic                         copy_last;

    dpfl_ptab u_ptab (
        .clk    (clk),
        .rst_n  (rst_n),
        .policy (policy_reg),
        .cmd    (pt_cmd),
        .stat   (pt_stat)
    );

    dpfl_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mem_ctl),
        .phys_wdata (phys_wdata),
        .back_wdata (phys_rdata),
        .phys_rdata (phys_rdata),
        .back_rdata (back_rdata)
    );

    assign in_stall  = (state_reg != dpfl_pkg::S_IDLE);
    assign cfg_ready = (state_reg == dpfl_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

    // Copy engine: read word cnt, write the word read in the previous cycle.
    assign rd_off    = cnt_reg[dpfl_pkg::OFF_W-1:0];
    assign wr_off    = dpfl_pkg::OFF_W'(cnt_reg - 1'b1);
    assign copy_last = (cnt_reg == dpfl_pkg::CNT_W'(dpfl_pkg::PAGE_WORDS));

    always_comb
    begin
        state_next     = state_reg;
        policy_next    = policy_reg;
        out_valid_next = out_valid_reg;
        out_rsp_next   = out_rsp_reg;
        op_next        = op_reg;
        page_next      = page_reg;
        off_next       = off_reg;
        wdata_next     = wdata_reg;
        frame_next     = frame_reg;
        fault_next     = fault_reg;
        ev_next        = ev_reg;
        vp_next        = vp_reg;
        wb_next        = wb_reg;
        cnt_next       = cnt_reg;
        rdata_next     = rdata_reg;

        pt_cmd            = '0;
        pt_cmd.addr       = (state_reg == dpfl_pkg::S_VICT) ? vp_reg : page_reg;
        pt_cmd.frame      = frame_reg;

        mem_ctl            = '0;
        mem_ctl.phys_raddr = {frame_reg, off_reg};
        mem_ctl.phys_waddr = {frame_reg, off_reg};
        mem_ctl.back_raddr = {page_reg, rd_off};
        mem_ctl.back_waddr = {vp_reg, wr_off};
        phys_wdata         = wdata_reg;

        if (cfg_valid && cfg_ready)
        begin
            policy_next = dpfl_pkg::policy_t'(cfg_data);
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            dpfl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = dpfl_pkg::op_t'(in_req.op);
                    page_next  = in_req.vaddr[dpfl_pkg::VADDR_W-1:dpfl_pkg::OFF_W];
                    off_next   = in_req.vaddr[dpfl_pkg::OFF_W-1:0];
                    wdata_next = in_req.wdata;
                    state_next = dpfl_pkg::S_LOOK;
                end
            end
            dpfl_pkg::S_LOOK:
            begin
                ev_next  = 1'b0;
                vp_next  = '0;
                wb_next  = 1'b0;
                cnt_next = '0;
                if (pt_stat.valid)
                begin
                    fault_next = 1'b0;
                    frame_next = pt_stat.frame;
                    state_next = dpfl_pkg::S_ACC;
                end
                else
                begin
                    fault_next   = 1'b1;
                    pt_cmd.alloc = 1'b1;
                    frame_next   = pt_stat.alloc_frame;
                    if (pt_stat.alloc_evict)
                    begin
                        ev_next    = 1'b1;
                        vp_next    = pt_stat.alloc_owner;
                        state_next = dpfl_pkg::S_VICT;
                    end
                    else
                    begin
                        state_next = dpfl_pkg::S_FILL;
                    end
                end
            end
            dpfl_pkg::S_VICT:
            begin
                pt_cmd.unmap = 1'b1;
                wb_next      = pt_stat.dirty;
                state_next   = pt_stat.dirty ? dpfl_pkg::S_WB : dpfl_pkg::S_FILL;
            end
            dpfl_pkg::S_WB:
            begin
                mem_ctl.phys_raddr = {frame_reg, rd_off};
                mem_ctl.back_we    = (cnt_reg != '0);
                if (copy_last)
                begin
                    cnt_next   = '0;
                    state_next = dpfl_pkg::S_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            dpfl_pkg::S_FILL:
            begin
                mem_ctl.phys_we    = (cnt_reg != '0);
                mem_ctl.phys_waddr = {frame_reg, wr_off};
                phys_wdata         = back_rdata;
                if (copy_last)
                begin
                    pt_cmd.map = 1'b1;
                    state_next = dpfl_pkg::S_ACC;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            dpfl_pkg::S_ACC:
            begin
                pt_cmd.touch = 1'b1;
                if (op_reg == dpfl_pkg::OP_WRITE)
                begin
                    pt_cmd.mark_dirty = 1'b1;
                    mem_ctl.phys_we   = 1'b1;
                end
                state_next = dpfl_pkg::S_RD;
            end
            dpfl_pkg::S_RD:
            begin
                rdata_next = (op_reg == dpfl_pkg::OP_WRITE) ? '0 : phys_rdata;
                state_next = dpfl_pkg::S_DONE;
            end
            dpfl_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_rsp_next.rdata       = rdata_reg;
                    out_rsp_next.fault       = fault_reg;
                    out_rsp_next.evicted     = ev_reg;
                    out_rsp_next.victim_page = vp_reg;
                    out_rsp_next.wrote_back  = wb_reg;
                    out_rsp_next.frame       = frame_reg;
                    state_next               = dpfl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dpfl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dpfl_pkg::S_IDLE;
            policy_reg    <= dpfl_pkg::POL_FIFO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rsp_reg <= out_rsp_next;
        op_reg      <= op_next;
        page_reg    <= page_next;
        off_reg     <= off_next;
        wdata_reg   <= wdata_next;
        frame_reg   <= frame_next;
        fault_reg   <= fault_next;
        ev_reg      <= ev_next;
        vp_reg      <= vp_next;
        wb_reg      <= wb_next;
        cnt_reg     <= cnt_next;
        rdata_reg   <= rdata_next;
    end

    // Write-back only happens for an evicted victim.
    a_wb_needs_evict: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dpfl_pkg::S_WB |-> ev_reg && wb_reg)
        else $error("write-back without a dirty eviction");

    // A page load only follows a fault.
    a_fill_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dpfl_pkg::S_FILL |-> fault_reg)
        else $error("page load without a fault");

endmodule

`default_nettype wire

>>> test/demand_paging_fifo_lru_unit_tb.sv
module demand_paging_fifo_lru_unit_tb;

    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int LONG_HOLD   = 300;

    typedef enum logic [0:0] {
        ROW_ACCESS,
        ROW_POLICY
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        dpfl_pkg::req_t     req;
        dpfl_pkg::policy_t  pol;
        logic               has_want;
        dpfl_pkg::rsp_t     want;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    dpfl_pkg::req_t    in_req;
    logic              out_valid;
    logic              out_stall;
    dpfl_pkg::rsp_t    out_rsp;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_data;

    // Shadow of the paging state, updated in the order requests are taken.
    dpfl_pkg::policy_t            cur_policy;
    logic                         pt_valid [dpfl_pkg::PAGE_COUNT];
    logic                         pt_dirty [dpfl_pkg::PAGE_COUNT];
    logic [dpfl_pkg::FRAME_W-1:0] pt_frame [dpfl_pkg::PAGE_COUNT];
    logic [dpfl_pkg::PAGE_W-1:0]  frame_owner [dpfl_pkg::FRAME_COUNT];
    logic                         frame_used [dpfl_pkg::FRAME_COUNT];
    logic [dpfl_pkg::FRAME_W-1:0] lru_rank [dpfl_pkg::FRAME_COUNT];
    logic [dpfl_pkg::FRAME_W-1:0] fifo_ptr;
    dpfl_pkg::data_t              phys_mem [dpfl_pkg::PHYS_SIZE];
    dpfl_pkg::data_t              backing_mem [dpfl_pkg::BACK_SIZE];

    dpfl_pkg::rsp_t access_outcomes[$];
    stim_row_t      dir_rows[$];
    int             mismatch_count;
    bit             tx_idle;
    bit             rx_idle;
    bit             rx_hold_req;

    demand_paging_fifo_lru_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    function automatic void clear_pager();
        int i;
        cur_policy = dpfl_pkg::POL_FIFO;
        for (i = 0; i < dpfl_pkg::PAGE_COUNT; i++)
        begin
            pt_valid[i] = 1'b0;
            pt_dirty[i] = 1'b0;
            pt_frame[i] = '0;
        end
        for (i = 0; i < dpfl_pkg::FRAME_COUNT; i++)
        begin
            frame_owner[i] = '0;
            frame_used[i]  = 1'b0;
            lru_rank[i]    = dpfl_pkg::FRAME_W'(i);
        end
        fifo_ptr = '0;
        for (i = 0; i < dpfl_pkg::PHYS_SIZE; i++)
            phys_mem[i] = '1;
        for (i = 0; i < dpfl_pkg::BACK_SIZE; i++)
            backing_mem[i] = '1;
    endfunction

    function automatic dpfl_pkg::rsp_t resolve_access(dpfl_pkg::req_t r);
        dpfl_pkg::rsp_t               o;
        int                           page;
        int                           off;
        int                           f;
        int                           vp;
        int                           i;
        logic [dpfl_pkg::FRAME_W-1:0] rk;
        o = '0;
        page = (int'(r.vaddr) / dpfl_pkg::PAGE_WORDS) % dpfl_pkg::PAGE_COUNT;
        off = int'(r.vaddr) % dpfl_pkg::PAGE_WORDS;
        if (pt_valid[page])
            f = int'(pt_frame[page]);
        else
        begin
            o.fault = 1'b1;
            f = dpfl_pkg::FRAME_COUNT;
            for (i = dpfl_pkg::FRAME_COUNT - 1; i >= 0; i--)
                if (!frame_used[i])
                    f = i;
            if (f == dpfl_pkg::FRAME_COUNT)
            begin
                if (cur_policy == dpfl_pkg::POL_FIFO)
                begin
                    f = int'(fifo_ptr);
                    fifo_ptr = fifo_ptr + 1'b1;
                end
                else
                begin
                    f = 0;
                    for (i = 1; i < dpfl_pkg::FRAME_COUNT; i++)
                        if (lru_rank[i] > lru_rank[f])
                            f = i;
                end
                vp = int'(frame_owner[f]);
                o.evicted = 1'b1;
                o.victim_page = dpfl_pkg::PAGE_W'(vp);
                if (pt_dirty[vp])
                begin
                    o.wrote_back = 1'b1;
                    for (i = 0; i < dpfl_pkg::PAGE_WORDS; i++)
                        backing_mem[vp * dpfl_pkg::PAGE_WORDS + i] =
                            phys_mem[f * dpfl_pkg::PAGE_WORDS + i];
                end
                pt_valid[vp] = 1'b0;
                pt_dirty[vp] = 1'b0;
            end
            for (i = 0; i < dpfl_pkg::PAGE_WORDS; i++)
                phys_mem[f * dpfl_pkg::PAGE_WORDS + i] =
                    backing_mem[page * dpfl_pkg::PAGE_WORDS + i];
            frame_used[f]  = 1'b1;
            frame_owner[f] = dpfl_pkg::PAGE_W'(page);
            pt_valid[page] = 1'b1;
            pt_dirty[page] = 1'b0;
            pt_frame[page] = dpfl_pkg::FRAME_W'(f);
        end

        // Every access makes its frame the most recent; newer frames age by one.
        rk = lru_rank[f];
        for (i = 0; i < dpfl_pkg::FRAME_COUNT; i++)
            if (lru_rank[i] < rk)
                lru_rank[i] = lru_rank[i] + 1'b1;
        lru_rank[f] = '0;

        if (r.op == dpfl_pkg::OP_WRITE)
        begin
            phys_mem[f * dpfl_pkg::PAGE_WORDS + off] = r.wdata;
            pt_dirty[page] = 1'b1;
        end
        else
            o.rdata = phys_mem[f * dpfl_pkg::PAGE_WORDS + off];
        o.frame = dpfl_pkg::FRAME_W'(f);
        return o;
    endfunction

    function automatic stim_row_t row_access(dpfl_pkg::op_t op, int vaddr,
                                             logic [31:0] wdata);
        stim_row_t r;
        r = '0;
        r.kind = ROW_ACCESS;
        r.req.op = op;
        r.req.vaddr = dpfl_pkg::VADDR_W'(vaddr);
        r.req.wdata = wdata;
        return r;
    endfunction

    function automatic stim_row_t row_checked(dpfl_pkg::op_t op, int vaddr,
                                              logic [31:0] wdata, logic [31:0] rd,
                                              int flt, int ev, int vp, int wb, int fr);
        stim_row_t r;
        r = row_access(op, vaddr, wdata);
        r.has_want = 1'b1;
        r.want.rdata = rd;
        r.want.fault = 1'(flt);
        r.want.evicted = 1'(ev);
        r.want.victim_page = dpfl_pkg::PAGE_W'(vp);
        r.want.wrote_back = 1'(wb);
        r.want.frame = dpfl_pkg::FRAME_W'(fr);
        return r;
    endfunction

    function automatic stim_row_t row_policy(dpfl_pkg::policy_t p);
        stim_row_t r;
        r = '0;
        r.kind = ROW_POLICY;
        r.pol = p;
        return r;
    endfunction

    // Most requests stay in a five-page working set, so hits, evictions and
    // dirty write-backs all happen often; the rest go anywhere.
    function automatic dpfl_pkg::req_t random_access(int hot_base);
        dpfl_pkg::req_t              r;
        logic [dpfl_pkg::PAGE_W-1:0] pg;
        logic [dpfl_pkg::OFF_W-1:0]  off;
        if ($urandom_range(0, 9) < 8)
            pg = dpfl_pkg::PAGE_W'((hot_base + $urandom_range(0, 4)) % dpfl_pkg::PAGE_COUNT);
        else
            pg = dpfl_pkg::PAGE_W'($urandom_range(0, dpfl_pkg::PAGE_COUNT - 1));
        off = dpfl_pkg::OFF_W'($urandom_range(0, dpfl_pkg::PAGE_WORDS - 1));
        r.op = $urandom_range(0, 1) ? dpfl_pkg::OP_WRITE : dpfl_pkg::OP_READ;
        r.vaddr = {pg, off};
        case ($urandom_range(0, 15))
            0:       r.wdata = 32'h8000_0000;
            1:       r.wdata = 32'h7fff_ffff;
            2:       r.wdata = '0;
            3:       r.wdata = '1;
            default: r.wdata = $urandom();
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch in %s: got %h, expected %h", what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin : check_results
        dpfl_pkg::rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (access_outcomes.size() == 0)
                report_mismatch("unexpected result rdata", out_rsp.rdata, '0);
            else
            begin
                want = access_outcomes.pop_front();
                check_field("rdata", out_rsp.rdata, want.rdata);
                check_field("fault", 32'(out_rsp.fault), 32'(want.fault));
                check_field("evicted", 32'(out_rsp.evicted), 32'(want.evicted));
                check_field("victim_page", 32'(out_rsp.victim_page),
                            32'(want.victim_page));
                check_field("wrote_back", 32'(out_rsp.wrote_back), 32'(want.wrote_back));
                check_field("frame", 32'(out_rsp.frame), 32'(want.frame));
            end
        end
    end

    // Result side: random stall before each result while rx_idle is set, and one
    // long hold-off when asked, so that the block fills up and stalls its input.
    initial
    begin : result_sink
        int stall_len;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                stall_len = LONG_HOLD;
                rx_hold_req = 1'b0;
            end
            else
                stall_len = rx_idle ? $urandom_range(0, 14) : 0;
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            @(negedge clk);
        end
    end

    task automatic send_request(input dpfl_pkg::req_t r, input logic has_want,
                                input dpfl_pkg::rsp_t want);
        int             gap;
        dpfl_pkg::rsp_t got;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req <= r;
        do
            @(posedge clk);
        while (in_stall);
        got = resolve_access(r);
        access_outcomes.push_back(has_want ? want : got);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (access_outcomes.size() != 0);
    endtask

    task automatic write_policy(input dpfl_pkg::policy_t p);
        cfg_valid <= 1'b1;
        cfg_data <= p;
        do
            @(posedge clk);
        while (!cfg_ready);
        cur_policy = p;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int phase;
        int n;
        int hot_base;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_req = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        mismatch_count = 0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        rx_hold_req = 1'b0;
        hot_base = 0;
        clear_pager();

        // Fill all four frames, then evict under FIFO with dirty and clean victims.
        dir_rows.push_back(row_policy(dpfl_pkg::POL_FIFO));
        dir_rows.push_back(row_checked(dpfl_pkg::OP_READ, 0, 0, 32'hffff_ffff,
                                       1, 0, 0, 0, 0));
        dir_rows.push_back(row_checked(dpfl_pkg::OP_WRITE, 7, 32'h7fff_ffff, 0,
                                       0, 0, 0, 0, 0));
        dir_rows.push_back(row_checked(dpfl_pkg::OP_READ, 7, 0, 32'h7fff_ffff,
                                       0, 0, 0, 0, 0));
        dir_rows.push_back(row_checked(dpfl_pkg::OP_WRITE, 127, 32'h8000_0000, 0,
                                       1, 0, 0, 0, 1));
        dir_rows.push_back(row_checked(dpfl_pkg::OP_READ, 127, 0, 32'h8000_0000,
                                       0, 0, 0, 0, 1));
        dir_rows.push_back(row_checked(dpfl_pkg::OP_READ, 8, 0, 32'hffff_ffff,
                                       1, 0, 0, 0, 2));
        dir_rows.push_back(row_checked(dpfl_pkg::OP_WRITE, 16, 0, 0,
                                       1, 0, 0, 0, 3));
        dir_rows.push_back(row_checked(dpfl_pkg::OP_READ, 24, 0, 32'hffff_ffff,
                                       1, 1, 0, 1, 0));
        dir_rows.push_back(row_checked(dpfl_pkg::OP_READ, 7, 0, 32'h7fff_ffff,
                                       1, 1, 15, 1, 1));
        dir_rows.push_back(row_checked(dpfl_pkg::OP_READ, 120, 0, 32'hffff_ffff,
                                       1, 1, 1, 0, 2));
        dir_rows.push_back(row_checked(dpfl_pkg::OP_READ, 127, 0, 32'h8000_0000,
                                       0, 0, 0, 0, 2));
        // LRU evictions must leave the FIFO pointer where it was.
        dir_rows.push_back(row_policy(dpfl_pkg::POL_LRU));
        dir_rows.push_back(row_access(dpfl_pkg::OP_WRITE, 25, 32'hffff_ffff));
        dir_rows.push_back(row_access(dpfl_pkg::OP_READ, 48, 0));
        dir_rows.push_back(row_access(dpfl_pkg::OP_WRITE, 50, 32'h5555_5555));
        dir_rows.push_back(row_access(dpfl_pkg::OP_READ, 8, 0));
        dir_rows.push_back(row_access(dpfl_pkg::OP_READ, 16, 0));
        dir_rows.push_back(row_policy(dpfl_pkg::POL_FIFO));
        dir_rows.push_back(row_access(dpfl_pkg::OP_READ, 64, 0));
        dir_rows.push_back(row_access(dpfl_pkg::OP_WRITE, 95, 32'haaaa_aaaa));
        dir_rows.push_back(row_access(dpfl_pkg::OP_READ, 95, 0));
        dir_rows.push_back(row_access(dpfl_pkg::OP_READ, 50, 0));
        dir_rows.push_back(row_access(dpfl_pkg::OP_READ, 25, 0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].kind == ROW_POLICY)
            begin
                drain_results();
                write_policy(dir_rows[k].pol);
            end
            else
                send_request(dir_rows[k].req, dir_rows[k].has_want, dir_rows[k].want);
        end

        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            drain_results();
            write_policy((phase % 2 == 0) ? dpfl_pkg::POL_LRU : dpfl_pkg::POL_FIFO);
            tx_idle = !(phase == 2 || phase == 5);
            rx_idle = (phase != 2);
            if (phase == 5)
                rx_hold_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 50 == 0)
                    hot_base = $urandom_range(0, dpfl_pkg::PAGE_COUNT - 1);
                // Now and then the sender waits for every outstanding request.
                if (n > 0 && n % 100 == 0)
                    drain_results();
                send_request(random_access(hot_base), 1'b0, '0);
            end
        end

        drain_results();
        repeat (30) @(negedge clk);
        if (access_outcomes.size() != 0)
            report_mismatch("results never returned", access_outcomes.size(), 0);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
